@@ hdl/dll_pkg.sv @@
// Shared definitions for the doubly linked list manager: field widths,
// operation codes, status codes and default sizes. No dependencies.
`timescale 1ns / 1ps

package dll_pkg;

   // Widths of the channel fields
   localparam int OP_W      = 3;
   localparam int LIST_ID_W = 2;
   localparam int NODE_ID_W = 6;

   // Default pool and list counts
   localparam int NODE_COUNT_DEF = 64;
   localparam int LIST_COUNT_DEF = 4;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT    = 3'd0,
      OP_PUSH_BACK     = 3'd1,
      OP_INSERT_AFTER  = 3'd2,
      OP_INSERT_BEFORE = 3'd3,
      OP_REMOVE        = 3'd4
   } op_type;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

endpackage

@@ hdl/dll_channel_if.sv @@
// Request and response channel interfaces of the list manager.
// Depends on dll_pkg for the field widths.
`timescale 1ns / 1ps

interface dll_req_if;
   logic                           valid;
   logic                           ready;
   logic [dll_pkg::OP_W-1:0]       operation;
   logic [dll_pkg::LIST_ID_W-1:0]  list_id;
   logic [dll_pkg::NODE_ID_W-1:0]  node_index;
   logic [dll_pkg::NODE_ID_W-1:0]  position_index;

   modport source (output valid, operation, list_id, node_index, position_index,
                   input ready);
   modport sink   (input valid, operation, list_id, node_index, position_index,
                   output ready);
endinterface

interface dll_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           status;
   logic                           list_empty;
   logic [dll_pkg::NODE_ID_W-1:0]  head_node;
   logic [dll_pkg::NODE_ID_W-1:0]  tail_node;
   logic                           node_prev_valid;
   logic [dll_pkg::NODE_ID_W-1:0]  node_prev;
   logic                           node_next_valid;
   logic [dll_pkg::NODE_ID_W-1:0]  node_next;

   modport source (output valid, status, list_empty, head_node, tail_node,
                   node_prev_valid, node_prev, node_next_valid, node_next,
                   input ready);
   modport sink   (input valid, status, list_empty, head_node, tail_node,
                   node_prev_valid, node_prev, node_next_valid, node_next,
                   output ready);
endinterface

@@ hdl/doubly_linked_list_manager_core.sv @@
// A request beat taken in ST_IDLE passes ST_EXEC, then waits in ST_FINISH until the
// output register is free to take its response; no request is taken meanwhile. The two
// write ports (one per node memory) rewrite up to four node entries, in EXEC and FINISH.
// A stalled response is held in an output register while the next request is taken.
// Reset: synchronous, active high; afterwards a clearing pass zeroes every node memory
// entry in turn, with req ready low, so every list starts empty.
//
// Top level of the list manager. Depends on dll_pkg, dll_channel_if and dll_node_mem.
`timescale 1ns / 1ps

module doubly_linked_list_manager_core #(
   parameter int NODE_COUNT = dll_pkg::NODE_COUNT_DEF,
   parameter int LIST_COUNT = dll_pkg::LIST_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dll_req_if.sink    req_bus,
   dll_rsp_if.source  rsp_bus
);

   // Only lists that the list_id field can name get head/tail storage
   localparam int LIST_REACH = 1 << dll_pkg::LIST_ID_W;
   localparam int LIST_EFF   = (LIST_COUNT < LIST_REACH) ? LIST_COUNT : LIST_REACH;
   localparam int LIST_W     = (LIST_EFF > 1) ? $clog2(LIST_EFF) : 1;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int OWN_W      = $clog2(LIST_EFF + 1);

   // Node memory entries: the prev memory also carries the owner mark
   typedef struct packed {
      logic [OWN_W-1:0]  owner;
      logic              ok;
      logic [NODE_W-1:0] idx;
   } prev_ent_type;

   typedef struct packed {
      logic              ok;
      logic [NODE_W-1:0] idx;
   } link_type;

   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] addr;
      prev_ent_type      data;
   } prev_wr_type;

   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] addr;
      link_type          data;
   } next_wr_type;

   typedef struct packed {
      logic                           status;
      logic                           list_empty;
      logic [dll_pkg::NODE_ID_W-1:0]  head_node;
      logic [dll_pkg::NODE_ID_W-1:0]  tail_node;
      logic                           node_prev_valid;
      logic [dll_pkg::NODE_ID_W-1:0]  node_prev;
      logic                           node_next_valid;
      logic [dll_pkg::NODE_ID_W-1:0]  node_next;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_EXEC   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   state_type                      state_ff, state_in;
   logic [NODE_W-1:0]              clr_ff;
   logic [dll_pkg::OP_W-1:0]       op_ff;
   logic [dll_pkg::LIST_ID_W-1:0]  list_ff;
   logic [dll_pkg::NODE_ID_W-1:0]  node_ff;
   logic [dll_pkg::NODE_ID_W-1:0]  pos_ff;
   link_type                       head_ff [LIST_EFF];
   link_type                       tail_ff [LIST_EFF];
   prev_wr_type                    pw2_ff;
   next_wr_type                    nw2_ff;
   rsp_type                        res_ff;
   rsp_type                        out_ff;
   logic                           rsp_valid_ff;

   // ---------------------------------------------------------------
   // Node memories
   // ---------------------------------------------------------------
   prev_wr_type   pw_wr;
   next_wr_type   nw_wr;
   prev_ent_type  prd_a, prd_b;   // prev entries of node and position
   link_type      nrd_a, nrd_b;   // next links of node and position

   // Read at the request address every cycle; the data seen in ST_EXEC
   // belongs to the beat accepted at the edge that left ST_IDLE.
   dll_node_mem #(
      .DEPTH  (NODE_COUNT),
      .WIDTH  ($bits(prev_ent_type)),
      .ADDR_W (NODE_W)
   ) u_prev_mem (
      .clock     (clock),
      .wr_en     (pw_wr.en),
      .wr_addr   (pw_wr.addr),
      .wr_data   (pw_wr.data),
      .rd_addr_a (NODE_W'(req_bus.node_index)),
      .rd_addr_b (NODE_W'(req_bus.position_index)),
      .rd_data_a (prd_a),
      .rd_data_b (prd_b)
   );

   dll_node_mem #(
      .DEPTH  (NODE_COUNT),
      .WIDTH  ($bits(link_type)),
      .ADDR_W (NODE_W)
   ) u_next_mem (
      .clock     (clock),
      .wr_en     (nw_wr.en),
      .wr_addr   (nw_wr.addr),
      .wr_data   (nw_wr.data),
      .rd_addr_a (NODE_W'(req_bus.node_index)),
      .rd_addr_b (NODE_W'(req_bus.position_index)),
      .rd_data_a (nrd_a),
      .rd_data_b (nrd_b)
   );

   // ---------------------------------------------------------------
   // Operation decode (ST_EXEC)
   // ---------------------------------------------------------------
   logic               list_ok, node_ok, pos_ok, valid;
   logic [LIST_W-1:0]  li;
   logic [NODE_W-1:0]  n, p;
   logic [OWN_W-1:0]   mark;
   link_type           cur_hd, cur_tl, new_hd, new_tl, new_prev, new_next;
   prev_wr_type        pw1, pw2;
   next_wr_type        nw1, nw2;
   rsp_type            res;

   assign list_ok = 32'(list_ff) < LIST_COUNT;
   assign node_ok = 32'(node_ff) < NODE_COUNT;
   assign pos_ok  = 32'(pos_ff)  < NODE_COUNT;
   assign li      = LIST_W'(list_ff);
   assign n       = NODE_W'(node_ff);
   assign p       = NODE_W'(pos_ff);
   assign mark    = OWN_W'(32'(list_ff) + 32'd1);
   assign cur_hd  = list_ok ? head_ff[li] : '0;
   assign cur_tl  = list_ok ? tail_ff[li] : '0;

   // Every neighbor touched belongs to the addressed list, so its owner
   // mark is known and whole entries are written without a read.
   always_comb begin
      valid    = 1'b0;
      pw1      = '{en: 1'b0, addr: n, data: '0};
      nw1      = '{en: 1'b0, addr: n, data: '0};
      pw2      = '0;
      nw2      = '0;
      new_hd   = cur_hd;
      new_tl   = cur_tl;
      if (list_ok && node_ok) begin
         unique case (op_ff)
            dll_pkg::OP_PUSH_FRONT: begin
               valid    = (prd_a.owner == '0);
               pw1.data = '{owner: mark, ok: 1'b0, idx: '0};
               nw1.data = '{ok: cur_hd.ok, idx: cur_hd.ok ? cur_hd.idx : '0};
               pw2      = '{en: cur_hd.ok, addr: cur_hd.idx,
                            data: '{owner: mark, ok: 1'b1, idx: n}};
               new_hd   = '{ok: 1'b1, idx: n};
               if (!cur_tl.ok) begin
                  new_tl = '{ok: 1'b1, idx: n};
               end
            end
            dll_pkg::OP_PUSH_BACK: begin
               valid    = (prd_a.owner == '0);
               pw1.data = '{owner: mark, ok: cur_tl.ok, idx: cur_tl.ok ? cur_tl.idx : '0};
               nw1.data = '0;
               nw2      = '{en: cur_tl.ok, addr: cur_tl.idx, data: '{ok: 1'b1, idx: n}};
               new_tl   = '{ok: 1'b1, idx: n};
               if (!cur_hd.ok) begin
                  new_hd = '{ok: 1'b1, idx: n};
               end
            end
            dll_pkg::OP_INSERT_AFTER: begin
               valid    = pos_ok && (prd_b.owner == mark) && (prd_a.owner == '0);
               pw1.data = '{owner: mark, ok: 1'b1, idx: p};
               nw1.data = nrd_b;
               nw2      = '{en: 1'b1, addr: p, data: '{ok: 1'b1, idx: n}};
               pw2      = '{en: nrd_b.ok, addr: nrd_b.idx,
                            data: '{owner: mark, ok: 1'b1, idx: n}};
               if (!nrd_b.ok) begin
                  new_tl = '{ok: 1'b1, idx: n};
               end
            end
            dll_pkg::OP_INSERT_BEFORE: begin
               valid    = pos_ok && (prd_b.owner == mark) && (prd_a.owner == '0);
               pw1.data = '{owner: mark, ok: prd_b.ok, idx: prd_b.idx};
               nw1.data = '{ok: 1'b1, idx: p};
               pw2      = '{en: 1'b1, addr: p, data: '{owner: mark, ok: 1'b1, idx: n}};
               nw2      = '{en: prd_b.ok, addr: prd_b.idx, data: '{ok: 1'b1, idx: n}};
               if (!prd_b.ok) begin
                  new_hd = '{ok: 1'b1, idx: n};
               end
            end
            dll_pkg::OP_REMOVE: begin
               valid    = (prd_a.owner == mark);
               pw1.data = '0;
               nw1.data = '0;
               // Splice predecessor and successor around the node
               nw2      = '{en: prd_a.ok, addr: prd_a.idx, data: nrd_a};
               pw2      = '{en: nrd_a.ok, addr: nrd_a.idx,
                            data: '{owner: mark, ok: prd_a.ok, idx: prd_a.idx}};
               if (!prd_a.ok) begin
                  new_hd = nrd_a;
               end
               if (!nrd_a.ok) begin
                  new_tl = '{ok: prd_a.ok, idx: prd_a.idx};
               end
            end
            default: begin
               valid = 1'b0;
            end
         endcase
      end
      // A rejected beat changes nothing
      if (!valid) begin
         new_hd = cur_hd;
         new_tl = cur_tl;
      end
      pw1.en = valid;
      nw1.en = valid;
      pw2.en = pw2.en & valid;
      nw2.en = nw2.en & valid;
   end

   // Links of the named node after the operation
   always_comb begin
      if (valid) begin
         new_prev = '{ok: pw1.data.ok, idx: pw1.data.idx};
         new_next = nw1.data;
      end else begin
         new_prev = '{ok: prd_a.ok, idx: prd_a.idx};
         new_next = nrd_a;
      end
   end

   always_comb begin
      res.status          = valid ? dll_pkg::STATUS_OK : dll_pkg::STATUS_INVALID;
      res.list_empty      = !new_hd.ok;
      res.head_node       = new_hd.ok ? dll_pkg::NODE_ID_W'(new_hd.idx) : '0;
      res.tail_node       = new_hd.ok ? dll_pkg::NODE_ID_W'(new_tl.idx) : '0;
      res.node_prev_valid = node_ok && new_prev.ok;
      res.node_prev       = (node_ok && new_prev.ok) ? dll_pkg::NODE_ID_W'(new_prev.idx) : '0;
      res.node_next_valid = node_ok && new_next.ok;
      res.node_next       = (node_ok && new_next.ok) ? dll_pkg::NODE_ID_W'(new_next.idx) : '0;
   end

   // ---------------------------------------------------------------
   // Memory write port select
   // ---------------------------------------------------------------
   always_comb begin
      unique case (state_ff)
         ST_CLEAR: begin
            pw_wr = '{en: 1'b1, addr: clr_ff, data: '0};
            nw_wr = '{en: 1'b1, addr: clr_ff, data: '0};
         end
         ST_EXEC: begin
            pw_wr = pw1;
            nw_wr = nw1;
         end
         ST_FINISH: begin
            // Rewriting the same entry while the output stalls is harmless
            pw_wr = pw2_ff;
            nw_wr = nw2_ff;
         end
         ST_IDLE: begin
            pw_wr = '0;
            nw_wr = '0;
         end
         default: begin
            pw_wr = '0;
            nw_wr = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   logic req_fire, out_free;

   assign req_fire = req_bus.valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == NODE_W'(NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_bus.operation;
         list_ff <= req_bus.list_id;
         node_ff <= req_bus.node_index;
         pos_ff  <= req_bus.position_index;
      end
   end

   // List ends: commit on a successful operation
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIST_EFF; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else if (state_ff == ST_EXEC && valid) begin
         head_ff[li] <= new_hd;
         tail_ff[li] <= new_tl;
      end
   end

   // Hold the second write pair and the result for ST_FINISH
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         pw2_ff <= pw2;
         nw2_ff <= nw2;
         res_ff <= res;
      end
   end

   // Output register: load on finish when free, drop after the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && out_free) begin
         out_ff <= res_ff;
      end
   end

   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = out_ff.status;
   assign rsp_bus.list_empty      = out_ff.list_empty;
   assign rsp_bus.head_node       = out_ff.head_node;
   assign rsp_bus.tail_node       = out_ff.tail_node;
   assign rsp_bus.node_prev_valid = out_ff.node_prev_valid;
   assign rsp_bus.node_prev       = out_ff.node_prev;
   assign rsp_bus.node_next_valid = out_ff.node_next_valid;
   assign rsp_bus.node_next       = out_ff.node_next;

endmodule

@@ hdl/dll_node_mem.sv @@
// Node table memory: one write port, two registered read ports.
// Depends on dll_pkg for the default depth.
`timescale 1ns / 1ps

module dll_node_mem #(
   parameter int DEPTH  = dll_pkg::NODE_COUNT_DEF,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ hdl/dll_checker.sv @@
// Port-level checks for the list manager, bound to its top level.
// Depends on dll_pkg for field widths.
`timescale 1ns / 1ps

module dll_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_status,
   input logic                           rsp_list_empty,
   input logic [dll_pkg::NODE_ID_W-1:0]  rsp_head_node,
   input logic [dll_pkg::NODE_ID_W-1:0]  rsp_tail_node,
   input logic                           rsp_prev_valid,
   input logic [dll_pkg::NODE_ID_W-1:0]  rsp_prev,
   input logic                           rsp_next_valid,
   input logic [dll_pkg::NODE_ID_W-1:0]  rsp_next
);

   // Reset drops the response and starts the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("response or request ready after reset");

   // One beat at a time: the block is busy the cycle after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on back-to-back cycles");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_list_empty) && $stable(rsp_head_node)
         && $stable(rsp_tail_node) && $stable(rsp_prev_valid)
         && $stable(rsp_prev) && $stable(rsp_next_valid) && $stable(rsp_next))
      else $error("stalled response changed");

   // An empty list reports zero ends
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_empty |-> rsp_head_node == '0 && rsp_tail_node == '0)
      else $error("empty list with nonzero ends");

   // Missing links read as zero
   a_missing_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_prev_valid || rsp_prev == '0)
         && (rsp_next_valid || rsp_next == '0))
      else $error("missing link with nonzero index");

endmodule

bind doubly_linked_list_manager_core dll_checker u_dll_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_list_empty (rsp_bus.list_empty),
   .rsp_head_node  (rsp_bus.head_node),
   .rsp_tail_node  (rsp_bus.tail_node),
   .rsp_prev_valid (rsp_bus.node_prev_valid),
   .rsp_prev       (rsp_bus.node_prev),
   .rsp_next_valid (rsp_bus.node_next_valid),
   .rsp_next       (rsp_bus.node_next)
);
